>>> hdl/uerd_pkg.sv
// Shared types and codes for the USB event ring dispatcher.
// No dependencies; the slot store, top level and bench use it by scoped names.
package uerd_pkg;

	// Item kinds
	localparam logic [1:0] FUNC_EVENT = 2'd0;
	localparam logic [1:0] FUNC_OWN   = 2'd1;
	localparam logic [1:0] FUNC_TAKE  = 2'd2;

	// Record selectors for a take
	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_CTL  = 2'd1;
	localparam logic [1:0] KIND_INTR = 2'd2;

	// Dispatch routes
	localparam logic [2:0] ROUTE_NONE  = 3'd0;
	localparam logic [2:0] ROUTE_CMD   = 3'd1;
	localparam logic [2:0] ROUTE_CTL   = 3'd2;
	localparam logic [2:0] ROUTE_INTR  = 3'd3;
	localparam logic [2:0] ROUTE_SKIP  = 3'd4;
	localparam logic [2:0] ROUTE_STRAY = 3'd5;

	// Event types
	localparam logic [5:0] TYPE_NONE     = 6'd0;
	localparam logic [5:0] TYPE_TRANSFER = 6'd32;
	localparam logic [5:0] TYPE_CMD_DONE = 6'd33;

	// Control endpoint index
	localparam logic [4:0] EP_CONTROL = 5'd1;

	// Handler-busy flag in the dequeue pointer
	localparam logic [63:0] BUSY_BIT = 64'h8;

	// Register indexes
	localparam logic [7:0] CFG_SLOT_LIMIT = 8'd0;
	localparam logic [7:0] CFG_RING_BASE  = 8'd1;

	// Slot addresses travel at full width and are cut down in the store
	localparam int SLOT_ADDR_W = 8;

	typedef struct packed {
		logic       ep0;
		logic       intr;
		logic [4:0] ep;
	} own_t;

	typedef struct packed {
		logic [7:0]  cc;
		logic [23:0] res;
	} rec_t;

	typedef struct packed {
		logic                   en;
		logic [SLOT_ADDR_W-1:0] own_addr;
		logic [SLOT_ADDR_W-1:0] rec_addr;
	} store_rd_t;

	typedef struct packed {
		logic                   own_we;
		logic [SLOT_ADDR_W-1:0] own_addr;
		own_t                   own_data;
		logic                   ctl_we;
		logic                   intr_we;
		logic [SLOT_ADDR_W-1:0] rec_addr;
		rec_t                   rec_data;
		logic                   ctl_clr;
		logic                   intr_clr;
	} store_wr_t;

	typedef struct packed {
		own_t own;
		logic ctl_valid;
		rec_t ctl_data;
		logic intr_valid;
		rec_t intr_data;
	} lookup_t;

endpackage

>>> hdl/uerd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uerd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and read the old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/uerd_slot_store.sv
// Per-slot ownership, control and interrupt records: RAMs plus valid bits.
// Uses uerd_pkg and uerd_ram. Reads are issued at accept, results serve stage 1.
module uerd_slot_store #(
	parameter int SLOT_COUNT = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  uerd_pkg::store_rd_t rd,
	input  uerd_pkg::store_wr_t wr,
	output uerd_pkg::lookup_t   lk
);

	localparam int SW    = $clog2(SLOT_COUNT + 1);
	localparam int DEPTH = 1 << SW;
	localparam int OWN_W = $bits(uerd_pkg::own_t);
	localparam int REC_W = $bits(uerd_pkg::rec_t);

	logic [SW-1:0]    own_ra, rec_ra, own_wa, rec_wa;
	logic [SW-1:0]    own_addr_s1, rec_addr_s1;
	logic             own_byp_s1, ctl_byp_s1, intr_byp_s1;
	logic [OWN_W-1:0] own_bdat_s1, own_rdata;
	logic [REC_W-1:0] ctl_bdat_s1, intr_bdat_s1, ctl_rdata, intr_rdata;
	logic [DEPTH-1:0] own_vld_q, ctl_vld_q, intr_vld_q;

	assign own_ra = rd.own_addr[SW-1:0];
	assign rec_ra = rd.rec_addr[SW-1:0];
	assign own_wa = wr.own_addr[SW-1:0];
	assign rec_wa = wr.rec_addr[SW-1:0];

	uerd_ram #(.WIDTH(OWN_W), .DEPTH(DEPTH)) u_own_ram (
		.clk   (clk),
		.we    (wr.own_we),
		.waddr (own_wa),
		.wdata (wr.own_data),
		.re    (rd.en),
		.raddr (own_ra),
		.rdata (own_rdata)
	);

	uerd_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ctl_ram (
		.clk   (clk),
		.we    (wr.ctl_we),
		.waddr (rec_wa),
		.wdata (wr.rec_data),
		.re    (rd.en),
		.raddr (rec_ra),
		.rdata (ctl_rdata)
	);

	uerd_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_intr_ram (
		.clk   (clk),
		.we    (wr.intr_we),
		.waddr (rec_wa),
		.wdata (wr.rec_data),
		.re    (rd.en),
		.raddr (rec_ra),
		.rdata (intr_rdata)
	);

	// Capture read addresses and forward a write that lands in the read cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_byp_s1  <= 1'b0;
			ctl_byp_s1  <= 1'b0;
			intr_byp_s1 <= 1'b0;
		end else if (rd.en) begin
			own_byp_s1  <= wr.own_we && (own_wa == own_ra);
			ctl_byp_s1  <= wr.ctl_we && (rec_wa == rec_ra);
			intr_byp_s1 <= wr.intr_we && (rec_wa == rec_ra);
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			own_addr_s1  <= own_ra;
			rec_addr_s1  <= rec_ra;
			own_bdat_s1  <= wr.own_data;
			ctl_bdat_s1  <= wr.rec_data;
			intr_bdat_s1 <= wr.rec_data;
		end
	end

	// Set on write, clear on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_vld_q  <= '0;
			ctl_vld_q  <= '0;
			intr_vld_q <= '0;
		end else begin
			if (wr.own_we) begin
				own_vld_q[own_wa] <= 1'b1;
			end
			if (wr.ctl_we) begin
				ctl_vld_q[rec_wa] <= 1'b1;
			end
			if (wr.ctl_clr) begin
				ctl_vld_q[rec_addr_s1] <= 1'b0;
			end
			if (wr.intr_we) begin
				intr_vld_q[rec_wa] <= 1'b1;
			end
			if (wr.intr_clr) begin
				intr_vld_q[rec_addr_s1] <= 1'b0;
			end
		end
	end

	// Present the stage 1 view; an unowned slot reads as all zero
	always_comb begin
		lk.own = '0;
		if (own_vld_q[own_addr_s1]) begin
			lk.own = own_byp_s1 ? uerd_pkg::own_t'(own_bdat_s1)
				: uerd_pkg::own_t'(own_rdata);
		end
		lk.ctl_valid  = ctl_vld_q[rec_addr_s1];
		lk.ctl_data   = ctl_byp_s1 ? uerd_pkg::rec_t'(ctl_bdat_s1)
			: uerd_pkg::rec_t'(ctl_rdata);
		lk.intr_valid = intr_vld_q[rec_addr_s1];
		lk.intr_data  = intr_byp_s1 ? uerd_pkg::rec_t'(intr_bdat_s1)
			: uerd_pkg::rec_t'(intr_rdata);
	end

endmodule

>>> hdl/usb_event_ring_dispatcher.sv
// Top level of the USB event ring dispatcher: input stage, dispatch and result register.
// Uses uerd_pkg and uerd_slot_store.
//
// One item is accepted per clock while out_ready keeps the result register moving; an
// accepted item is held in the input stage and its result is then loaded into the output
// register, so the sustained rate is one item per cycle while out_ready stays high. The
// slot store's ownership and record RAMs are read at the accepting edge and their
// registered data serves the input stage, where the dispatch decision, all state updates
// and the 64-bit dequeue pointer add are done in a single pass. Configuration writes are
// always taken and must only be issued while no item is in flight.
module usb_event_ring_dispatcher #(
	parameter int RING_ENTRIES = 256,
	parameter int SLOT_COUNT   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// Items in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] trb_control,
	input  logic [31:0] trb_status,
	input  logic [5:0]  slot_sel,
	input  logic        ep0_owned,
	input  logic        intr_owned,
	input  logic [4:0]  intr_endpoint,
	input  logic [1:0]  owner_kind,
	// Results out
	output logic        out_valid,
	input  logic        out_ready,
	output logic        consumed,
	output logic [2:0]  route,
	output logic [7:0]  ring_index,
	output logic        cycle_state,
	output logic [63:0] dequeue_pointer,
	output logic        pending_valid,
	output logic [7:0]  pending_slot,
	output logic [7:0]  completion_code,
	output logic [23:0] residual_length,
	output logic [31:0] stray_count
);

	localparam int          PW       = $clog2(RING_ENTRIES);
	localparam logic [PW-1:0] POS_LAST = PW'(RING_ENTRIES - 1);
	localparam logic [7:0]  SLOT_MAX = 8'(SLOT_COUNT);

	logic in_acc, adv, go;

	// Configuration registers
	logic [5:0]  slot_limit_q;
	logic [63:0] ring_base_q;

	// Ring and record state
	logic [PW-1:0] pos_q;
	logic          cycle_q;
	logic          cmd_vld_q;
	logic [7:0]    cmd_slot_q, cmd_cc_q;
	logic [31:0]   stray_q;

	// Input stage
	logic        v_s1;
	logic [1:0]  func_s1, kind_s1;
	logic [31:0] ctrl_s1, stat_s1;
	logic [5:0]  sel_s1;
	logic        ep0_s1, intr_s1;
	logic [4:0]  iep_s1;

	// Result register
	logic        out_valid_q, consumed_q, cycle_out_q, pvld_q;
	logic [2:0]  route_q;
	logic [7:0]  ring_index_q, pslot_q, pcc_q;
	logic [63:0] dq_q;
	logic [23:0] pres_q;
	logic [31:0] stray_out_q;

	// Stage 1 decode
	logic [5:0]    ev_type;
	logic [7:0]    ev_slot, ev_cc, sel8;
	logic [4:0]    ev_ep;
	logic [23:0]   ev_res;
	logic          ev_take, slot_bad, sel_ok, wrap;
	logic [2:0]    ev_route;
	logic [PW-1:0] pos_nxt;
	logic          cycle_nxt;
	logic [31:0]   stray_nxt;
	logic [15:0]   pos16;
	logic [63:0]   dq_nxt;
	logic          tk_vld;
	logic [7:0]    tk_slot, tk_cc;
	logic [23:0]   tk_res;

	uerd_pkg::store_rd_t st_rd;
	uerd_pkg::store_wr_t st_wr;
	uerd_pkg::lookup_t   st_lk;

	// Handshake
	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !v_s1 || adv;
	assign in_acc    = in_valid && in_ready;
	assign go        = v_s1 && adv;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= 6'd32;
			ring_base_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uerd_pkg::CFG_SLOT_LIMIT: slot_limit_q <= cfg_data[5:0];
				uerd_pkg::CFG_RING_BASE:  ring_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Load the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= func;
			ctrl_s1 <= trb_control;
			stat_s1 <= trb_status;
			sel_s1  <= slot_sel;
			ep0_s1  <= ep0_owned;
			intr_s1 <= intr_owned;
			iep_s1  <= intr_endpoint;
			kind_s1 <= owner_kind;
		end
	end

	// Issue slot store reads at accept
	assign st_rd.en       = in_acc;
	assign st_rd.own_addr = trb_control[31:24];
	assign st_rd.rec_addr = {2'b00, slot_sel};

	uerd_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (st_rd),
		.wr     (st_wr),
		.lk     (st_lk)
	);

	// Decode the event words
	assign ev_type = ctrl_s1[15:10];
	assign ev_slot = ctrl_s1[31:24];
	assign ev_ep   = ctrl_s1[20:16];
	assign ev_cc   = stat_s1[31:24];
	assign ev_res  = stat_s1[23:0];
	assign sel8    = {2'b00, sel_s1};
	assign sel_ok  = (sel8 != 8'd0) && (sel8 <= SLOT_MAX);
	assign ev_take = (func_s1 == uerd_pkg::FUNC_EVENT) && (ctrl_s1[0] == cycle_q)
		&& (ev_type != uerd_pkg::TYPE_NONE);
	assign slot_bad = (ev_slot == 8'd0) || (ev_slot > {2'b00, slot_limit_q})
		|| (ev_slot > SLOT_MAX);

	// Pick the route of an event
	always_comb begin
		if (ev_type == uerd_pkg::TYPE_CMD_DONE) begin
			ev_route = uerd_pkg::ROUTE_CMD;
		end else if (ev_type != uerd_pkg::TYPE_TRANSFER) begin
			ev_route = uerd_pkg::ROUTE_SKIP;
		end else if (slot_bad) begin
			ev_route = uerd_pkg::ROUTE_STRAY;
		end else if (ev_ep == uerd_pkg::EP_CONTROL && st_lk.own.ep0) begin
			ev_route = uerd_pkg::ROUTE_CTL;
		end else if (st_lk.own.intr && ev_ep == st_lk.own.ep) begin
			ev_route = uerd_pkg::ROUTE_INTR;
		end else begin
			ev_route = uerd_pkg::ROUTE_STRAY;
		end
	end

	// Advance the ring head
	assign wrap      = (pos_q == POS_LAST);
	assign pos_nxt   = ev_take ? (wrap ? '0 : pos_q + 1'b1) : pos_q;
	assign cycle_nxt = (ev_take && wrap) ? ~cycle_q : cycle_q;
	assign stray_nxt = stray_q + 32'((ev_take && ev_route == uerd_pkg::ROUTE_STRAY) ? 1 : 0);
	assign pos16     = 16'(pos_nxt);
	assign dq_nxt    = (ring_base_q + (64'(pos16) << 4)) | uerd_pkg::BUSY_BIT;

	// Take a pending record
	always_comb begin
		tk_vld  = 1'b0;
		tk_slot = '0;
		tk_cc   = '0;
		tk_res  = '0;
		if (func_s1 == uerd_pkg::FUNC_TAKE) begin
			case (kind_s1)
				uerd_pkg::KIND_CMD: begin
					if (cmd_vld_q) begin
						tk_vld  = 1'b1;
						tk_slot = cmd_slot_q;
						tk_cc   = cmd_cc_q;
					end
				end
				uerd_pkg::KIND_CTL: begin
					if (sel_ok && st_lk.ctl_valid) begin
						tk_vld  = 1'b1;
						tk_slot = sel8;
						tk_cc   = st_lk.ctl_data.cc;
						tk_res  = st_lk.ctl_data.res;
					end
				end
				uerd_pkg::KIND_INTR: begin
					if (sel_ok && st_lk.intr_valid) begin
						tk_vld  = 1'b1;
						tk_slot = sel8;
						tk_cc   = st_lk.intr_data.cc;
						tk_res  = st_lk.intr_data.res;
					end
				end
				default: ;
			endcase
		end
	end

	// Drive slot store writes from the item in stage 1
	always_comb begin
		st_wr               = '0;
		st_wr.own_addr      = sel8;
		st_wr.own_data.ep0  = ep0_s1;
		st_wr.own_data.intr = intr_s1;
		st_wr.own_data.ep   = iep_s1;
		st_wr.rec_addr      = ev_slot;
		st_wr.rec_data.cc   = ev_cc;
		st_wr.rec_data.res  = ev_res;
		if (go) begin
			st_wr.own_we   = (func_s1 == uerd_pkg::FUNC_OWN) && sel_ok;
			st_wr.ctl_we   = ev_take && (ev_route == uerd_pkg::ROUTE_CTL);
			st_wr.intr_we  = ev_take && (ev_route == uerd_pkg::ROUTE_INTR);
			st_wr.ctl_clr  = tk_vld && (kind_s1 == uerd_pkg::KIND_CTL);
			st_wr.intr_clr = tk_vld && (kind_s1 == uerd_pkg::KIND_INTR);
		end
	end

	// Commit ring, command record and stray count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			cycle_q    <= 1'b1;
			cmd_vld_q  <= 1'b0;
			cmd_slot_q <= '0;
			cmd_cc_q   <= '0;
			stray_q    <= '0;
		end else if (go) begin
			pos_q   <= pos_nxt;
			cycle_q <= cycle_nxt;
			stray_q <= stray_nxt;
			if (ev_take && ev_route == uerd_pkg::ROUTE_CMD) begin
				cmd_vld_q  <= 1'b1;
				cmd_slot_q <= ev_slot;
				cmd_cc_q   <= ev_cc;
			end else if (tk_vld && kind_s1 == uerd_pkg::KIND_CMD) begin
				cmd_vld_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			consumed_q   <= ev_take;
			route_q      <= ev_take ? ev_route : uerd_pkg::ROUTE_NONE;
			ring_index_q <= pos16[7:0];
			cycle_out_q  <= cycle_nxt;
			dq_q         <= dq_nxt;
			pvld_q       <= tk_vld;
			pslot_q      <= tk_slot;
			pcc_q        <= tk_cc;
			pres_q       <= tk_res;
			stray_out_q  <= stray_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign consumed        = consumed_q;
	assign route           = route_q;
	assign ring_index      = ring_index_q;
	assign cycle_state     = cycle_out_q;
	assign dequeue_pointer = dq_q;
	assign pending_valid   = pvld_q;
	assign pending_slot    = pslot_q;
	assign completion_code = pcc_q;
	assign residual_length = pres_q;
	assign stray_count     = stray_out_q;

endmodule

>>> hdl/uerd_checker.sv
// Port-level checks for the USB event ring dispatcher, bound to the top level.
// Uses only the top level's ports; no package dependency.
module uerd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        consumed,
	input logic [2:0]  route,
	input logic [63:0] dequeue_pointer,
	input logic        pending_valid,
	input logic [7:0]  pending_slot,
	input logic [7:0]  completion_code,
	input logic [23:0] residual_length,
	input logic [31:0] stray_count
);

	// A stalled result stays valid with its route and stray count unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(route) && $stable(stray_count))
		else $error("result changed while stalled");

	// A consumed entry always carries a dispatch route
	a_route_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && consumed |-> route != 3'd0 && route <= 3'd5)
		else $error("consumed entry without a route");

	// A refused entry or non-event item reports no route
	a_route_clr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !consumed |-> route == 3'd0)
		else $error("route reported without consumption");

	// Dequeue pointer always shows the handler-busy flag
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dequeue_pointer[3])
		else $error("handler-busy flag missing");

	// A result without a pending record reports zero record fields
	a_take_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pending_valid |->
			pending_slot == 8'd0 && completion_code == 8'd0 && residual_length == 24'd0)
		else $error("record fields set without a pending record");

endmodule

bind usb_event_ring_dispatcher uerd_checker u_uerd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.consumed        (consumed),
	.route           (route),
	.dequeue_pointer (dequeue_pointer),
	.pending_valid   (pending_valid),
	.pending_slot    (pending_slot),
	.completion_code (completion_code),
	.residual_length (residual_length),
	.stray_count     (stray_count)
);

>>> bench/ring_check_pkg.sv
// Item and result records plus the scoreboard for the event ring dispatcher bench.
// Depends on uerd_pkg for item kinds, routes, event types and register indexes.
package ring_check_pkg;

	localparam int NUM_SLOTS  = 32;
	localparam int RING_DEPTH = 256;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] trb_control;
		logic [31:0] trb_status;
		logic [5:0]  slot_sel;
		logic        ep0_owned;
		logic        intr_owned;
		logic [4:0]  intr_endpoint;
		logic [1:0]  owner_kind;
	} ring_item_t;

	typedef struct {
		logic        consumed;
		logic [2:0]  route;
		logic [7:0]  ring_index;
		logic        cycle_state;
		logic [63:0] dequeue_pointer;
		logic        pending_valid;
		logic [7:0]  pending_slot;
		logic [7:0]  completion_code;
		logic [23:0] residual_length;
		logic [31:0] stray_count;
	} ring_outcome_t;

	typedef struct {
		bit        valid;
		bit [7:0]  slot;
		bit [7:0]  cc;
		bit [23:0] res;
	} held_record_t;

	typedef struct {
		bit       ep0;
		bit       intr;
		bit [4:0] ep;
	} slot_owner_t;

	class dispatch_scoreboard;
		bit [5:0]      slot_limit;
		bit [63:0]     ring_base;
		int            head;
		bit            cycle;
		held_record_t  cmd_rec;
		held_record_t  ctl_rec [0:NUM_SLOTS];
		held_record_t  intr_rec [0:NUM_SLOTS];
		slot_owner_t   owner [0:NUM_SLOTS];
		bit [31:0]     strays;
		ring_outcome_t due_outcomes [$];
		int            errors;

		function new();
			slot_limit = 6'd32;
			ring_base = '0;
			head = 0;
			cycle = 1'b1;
			strays = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [7:0] index, logic [63:0] value);
			case (index)
			uerd_pkg::CFG_SLOT_LIMIT: slot_limit = value[5:0];
			uerd_pkg::CFG_RING_BASE: ring_base = value;
			default: ;
			endcase
		endfunction

		// Apply one accepted item to the shadow state and queue its outcome
		function void note_item(ring_item_t it);
			ring_outcome_t o;
			held_record_t  taken;
			bit            sel_ok;
			bit [5:0]      kind;
			bit [7:0]      slot;
			bit [4:0]      ep;
			bit [7:0]      cc;
			bit [23:0]     res;
			o = '{default: '0};
			taken = '{default: '0};
			sel_ok = it.slot_sel != 6'd0 && int'(it.slot_sel) <= NUM_SLOTS;
			kind = it.trb_control[15:10];
			slot = it.trb_control[31:24];
			ep = it.trb_control[20:16];
			cc = it.trb_status[31:24];
			res = it.trb_status[23:0];
			case (it.func)
			uerd_pkg::FUNC_EVENT: begin
				// Refuse entries the producer has not handed over yet and entries with no type
				if (it.trb_control[0] == cycle && kind != uerd_pkg::TYPE_NONE) begin
					o.consumed = 1'b1;
					if (kind == uerd_pkg::TYPE_CMD_DONE) begin
						cmd_rec = '{1'b1, slot, cc, 24'd0};
						o.route = uerd_pkg::ROUTE_CMD;
					end else if (kind != uerd_pkg::TYPE_TRANSFER) begin
						o.route = uerd_pkg::ROUTE_SKIP;
					end else if (slot == 8'd0 || slot > slot_limit
							|| int'(slot) > NUM_SLOTS) begin
						o.route = uerd_pkg::ROUTE_STRAY;
					end else if (ep == uerd_pkg::EP_CONTROL && owner[slot].ep0) begin
						ctl_rec[slot] = '{1'b1, slot, cc, res};
						o.route = uerd_pkg::ROUTE_CTL;
					end else if (owner[slot].intr && ep == owner[slot].ep) begin
						intr_rec[slot] = '{1'b1, slot, cc, res};
						o.route = uerd_pkg::ROUTE_INTR;
					end else begin
						o.route = uerd_pkg::ROUTE_STRAY;
					end
					if (o.route == uerd_pkg::ROUTE_STRAY)
						strays = strays + 32'd1;
					// Advance the head and flip the cycle on wrap
					head = (head + 1) % RING_DEPTH;
					if (head == 0)
						cycle = ~cycle;
				end
			end
			uerd_pkg::FUNC_OWN: begin
				if (sel_ok)
					owner[it.slot_sel] = '{it.ep0_owned, it.intr_owned, it.intr_endpoint};
			end
			uerd_pkg::FUNC_TAKE: begin
				// Hand out the record if it holds a completion, then drop it
				case (it.owner_kind)
				uerd_pkg::KIND_CMD: begin
					if (cmd_rec.valid)
						taken = cmd_rec;
					cmd_rec.valid = 1'b0;
				end
				uerd_pkg::KIND_CTL: begin
					if (sel_ok) begin
						if (ctl_rec[it.slot_sel].valid)
							taken = ctl_rec[it.slot_sel];
						ctl_rec[it.slot_sel].valid = 1'b0;
					end
				end
				uerd_pkg::KIND_INTR: begin
					if (sel_ok) begin
						if (intr_rec[it.slot_sel].valid)
							taken = intr_rec[it.slot_sel];
						intr_rec[it.slot_sel].valid = 1'b0;
					end
				end
				default: ;
				endcase
			end
			default: ;
			endcase
			o.ring_index = head[7:0];
			o.cycle_state = cycle;
			o.dequeue_pointer = (ring_base + 64'(head) * 64'd16) | uerd_pkg::BUSY_BIT;
			o.pending_valid = taken.valid;
			o.pending_slot = taken.slot;
			o.completion_code = taken.cc;
			o.residual_length = taken.res;
			o.stray_count = strays;
			due_outcomes.push_back(o);
		endfunction

		task report(string msg);
			$display("tb: mismatch: %s", msg);
			errors++;
		endtask

		task compare(string field, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s got %0h, expected %0h", field, got, want));
		endtask

		// Match one result beat against the oldest outstanding outcome
		task check_outcome(ring_outcome_t got);
			ring_outcome_t want;
			if (due_outcomes.size() == 0) begin
				report("result beat with nothing outstanding");
				return;
			end
			want = due_outcomes.pop_front();
			compare("consumed", got.consumed, want.consumed);
			compare("route", got.route, want.route);
			compare("ring_index", got.ring_index, want.ring_index);
			compare("cycle_state", got.cycle_state, want.cycle_state);
			compare("dequeue_pointer", got.dequeue_pointer, want.dequeue_pointer);
			compare("pending_valid", got.pending_valid, want.pending_valid);
			compare("pending_slot", got.pending_slot, want.pending_slot);
			compare("completion_code", got.completion_code, want.completion_code);
			compare("residual_length", got.residual_length, want.residual_length);
			compare("stray_count", got.stray_count, want.stray_count);
		endtask
	endclass

endpackage

>>> bench/tb.sv
// Bench top for the USB event ring dispatcher: clock, reset, drivers and monitors.
// Depends on uerd_pkg, ring_check_pkg and the dispatcher RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT    = 6;
	localparam int STALL_LIMIT = 2000;
	// Codes the package leaves unnamed
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [31:0] trb_control = '0;
	logic [31:0] trb_status = '0;
	logic [5:0]  slot_sel = '0;
	logic        ep0_owned = 1'b0;
	logic        intr_owned = 1'b0;
	logic [4:0]  intr_endpoint = '0;
	logic [1:0]  owner_kind = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        consumed;
	logic [2:0]  route;
	logic [7:0]  ring_index;
	logic        cycle_state;
	logic [63:0] dequeue_pointer;
	logic        pending_valid;
	logic [7:0]  pending_slot;
	logic [7:0]  completion_code;
	logic [23:0] residual_length;
	logic [31:0] stray_count;

	bit                                 steady = 1'b0;
	int                                 quiet_cycles = 0;
	ring_check_pkg::dispatch_scoreboard board = new();

	usb_event_ring_dispatcher dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Feed accepted beats to the scoreboard
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_item('{func, trb_control, trb_status, slot_sel, ep0_owned,
				intr_owned, intr_endpoint, owner_kind});
		if (arst_n && out_valid && out_ready)
			board.check_outcome('{consumed, route, ring_index, cycle_state, dequeue_pointer,
				pending_valid, pending_slot, completion_code, residual_length, stray_count});
	end

	// Stall the result side now and then
	always @(negedge clk)
		out_ready <= steady || $urandom_range(99) >= IDLE_PCT;

	// End the run when no beat moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic logic [31:0] event_word(bit cyc, bit [5:0] kind, bit [4:0] ep,
			bit [7:0] slot);
		return {slot, 3'b000, ep, kind, 9'd0, cyc};
	endfunction

	// Present one item at the falling edge and hold it until taken
	task automatic send_item(input ring_check_pkg::ring_item_t it);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		trb_control <= it.trb_control;
		trb_status <= it.trb_status;
		slot_sel <= it.slot_sel;
		ep0_owned <= it.ep0_owned;
		intr_owned <= it.intr_owned;
		intr_endpoint <= it.intr_endpoint;
		owner_kind <= it.owner_kind;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] index, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(index, value);
		@(negedge clk);
	endtask

	// Drop valid, wait out every outstanding result and the pipeline tail
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.due_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly well-formed events for the live cycle, plus ownership, takes and noise
	task automatic run_random(input int count);
		ring_check_pkg::ring_item_t it;
		int                         pick;
		int                         r;
		bit [7:0]                   slot;
		bit [5:0]                   kind;
		bit [4:0]                   ep;
		for (int n = 0; n < count; n++) begin
			it = '{2'($urandom()), $urandom(), $urandom(), 6'($urandom()), 1'($urandom()),
				1'($urandom()), 5'($urandom()), 2'($urandom())};
			pick = $urandom_range(99);
			if (pick < 62) begin
				it.func = uerd_pkg::FUNC_EVENT;
				r = $urandom_range(9);
				if (r < 5)
					kind = uerd_pkg::TYPE_TRANSFER;
				else if (r < 7)
					kind = uerd_pkg::TYPE_CMD_DONE;
				else if (r < 8)
					kind = uerd_pkg::TYPE_NONE;
				else
					kind = 6'($urandom_range(63));
				if ($urandom_range(99) < 85)
					slot = 8'($urandom_range(1, ring_check_pkg::NUM_SLOTS));
				else
					slot = 8'($urandom_range(255));
				r = $urandom_range(99);
				if (r < 45)
					ep = uerd_pkg::EP_CONTROL;
				else if (r < 80 && int'(slot) <= ring_check_pkg::NUM_SLOTS)
					ep = board.owner[slot].ep;
				else
					ep = 5'($urandom_range(31));
				it.trb_control[0] = ($urandom_range(9) == 0) ? ~board.cycle : board.cycle;
				it.trb_control[15:10] = kind;
				it.trb_control[20:16] = ep;
				it.trb_control[31:24] = slot;
			end else if (pick < 77) begin
				it.func = uerd_pkg::FUNC_OWN;
				if ($urandom_range(9) != 0)
					it.slot_sel = 6'($urandom_range(1, ring_check_pkg::NUM_SLOTS));
			end else if (pick < 95) begin
				it.func = uerd_pkg::FUNC_TAKE;
				r = $urandom_range(19);
				if (r < 6)
					it.owner_kind = uerd_pkg::KIND_CMD;
				else if (r < 12)
					it.owner_kind = uerd_pkg::KIND_CTL;
				else if (r < 18)
					it.owner_kind = uerd_pkg::KIND_INTR;
				else
					it.owner_kind = KIND_NONE;
				if ($urandom_range(9) != 0)
					it.slot_sel = 6'($urandom_range(1, ring_check_pkg::NUM_SLOTS));
			end else begin
				it.func = FUNC_SPARE;
			end
			send_item(it);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass on reset settings
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd0, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b0, uerd_pkg::TYPE_CMD_DONE, 5'd0, 8'd1), 32'd0,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_NONE, 5'd1, 8'd1), 32'd0,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_CMD_DONE, 5'd31, 8'd255), '1,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd0, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd0, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_OWN, 32'd0, 32'd0, 6'd1, 1'b1, 1'b1, 5'd31,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_OWN, 32'd0, 32'd0, 6'd32, 1'b0, 1'b1, 5'd0,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_OWN, 32'd0, 32'd0, 6'd0, 1'b1, 1'b1, 5'd1,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_OWN, 32'd0, 32'd0, 6'd63, 1'b1, 1'b1, 5'd1,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_TRANSFER, uerd_pkg::EP_CONTROL, 8'd1),
			32'h5A12_3456, 6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_TRANSFER, 5'd31, 8'd1), '1,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_TRANSFER, 5'd0, 8'd32), 32'h0100_0001,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_TRANSFER, uerd_pkg::EP_CONTROL, 8'd32), 32'd0,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_TRANSFER, uerd_pkg::EP_CONTROL, 8'd0), 32'd0,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT,
			event_word(1'b1, uerd_pkg::TYPE_TRANSFER, uerd_pkg::EP_CONTROL, 8'd33), 32'd0,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT, '1, '1, 6'd0, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_EVENT, event_word(1'b1, 6'd6, 5'd1, 8'd1), 32'd0,
			6'd0, 1'b0, 1'b0, 5'd0, uerd_pkg::KIND_CMD});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd1, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_CTL});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd1, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_INTR});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd32, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_INTR});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd0, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_CTL});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd63, 1'b0, 1'b0, 5'd0,
			uerd_pkg::KIND_INTR});
		send_item('{uerd_pkg::FUNC_TAKE, 32'd0, 32'd0, 6'd1, 1'b0, 1'b0, 5'd0, KIND_NONE});
		send_item('{FUNC_SPARE, '1, '1, '1, 1'b1, 1'b1, '1, KIND_NONE});

		// No slots enabled, base near the top so the pointer wraps
		settle();
		write_reg(uerd_pkg::CFG_SLOT_LIMIT, 64'd0);
		write_reg(uerd_pkg::CFG_RING_BASE, 64'hFFFF_FFFF_FFFF_FFC0);
		cfg_valid <= 1'b0;
		run_random(100);

		// All slots, random aligned base, no idling on either side
		settle();
		write_reg(uerd_pkg::CFG_SLOT_LIMIT, 64'd32);
		write_reg(uerd_pkg::CFG_RING_BASE, {$urandom(), $urandom()} & ~64'h3F);
		cfg_valid <= 1'b0;
		steady = 1'b1;
		run_random(150);
		steady = 1'b0;

		// Partial slot range, base of all ones
		settle();
		write_reg(uerd_pkg::CFG_SLOT_LIMIT, 64'($urandom_range(1, 31)));
		write_reg(uerd_pkg::CFG_RING_BASE, '1);
		cfg_valid <= 1'b0;
		run_random(100);

		// Back to reset values
		settle();
		write_reg(uerd_pkg::CFG_SLOT_LIMIT, 64'd32);
		write_reg(uerd_pkg::CFG_RING_BASE, 64'd0);
		cfg_valid <= 1'b0;
		run_random(100);

		settle();
		if (board.errors == 0 && board.due_outcomes.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
hdl/uerd_pkg.sv
hdl/uerd_ram.sv
hdl/uerd_slot_store.sv
hdl/usb_event_ring_dispatcher.sv
hdl/uerd_checker.sv
bench/ring_check_pkg.sv
bench/tb.sv
